// File: rtl/drt_pkg.sv
// Shared types and constants for the distance-vector route table.
// No dependencies; imported by every module of the block.
`default_nettype none
package drt_pkg;

    localparam int ROUTES_DEF    = 32;
    localparam int NEIGHBORS_DEF = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 48;

    localparam logic [7:0]  TTL_RESET    = 8'd15;
    localparam logic [7:0]  EXPIRY_RESET = 8'd10;
    localparam logic [15:0] COST_MAX     = 16'hFFFF;

    // action codes
    localparam logic [2:0] ACT_SEND   = 3'd0;
    localparam logic [2:0] ACT_DATA   = 3'd1;
    localparam logic [2:0] ACT_VSTART = 3'd2;
    localparam logic [2:0] ACT_VENTRY = 3'd3;
    localparam logic [2:0] ACT_VEND   = 3'd4;
    localparam logic [2:0] ACT_TICK   = 3'd5;

    // decision codes
    localparam logic [1:0] DEC_DELIVER = 2'd0;
    localparam logic [1:0] DEC_DROP    = 2'd1;
    localparam logic [1:0] DEC_UNICAST = 2'd2;
    localparam logic [1:0] DEC_FLOOD   = 2'd3;

    localparam logic KIND_DECISION = 1'b0;
    localparam logic KIND_DUMP     = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_TTL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_EXPIRY  = 3'd3;

    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] neighbor_mac;
        logic [31:0] neighbor_ip;
        logic [31:0] target_ip;
        logic [7:0]  ttl_in;
        logic [15:0] link_distance;
        logic [47:0] entry_next_hop;
        logic [15:0] entry_distance;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [1:0]  decision;
        logic [47:0] next_hop_mac;
        logic [7:0]  ttl_out;
        logic [31:0] dump_ip;
        logic [47:0] dump_next_hop;
        logic [15:0] dump_distance;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [31:0] dest;
        logic [47:0] hop;
        logic [15:0] cost;
    } route_entry_t;

endpackage
`default_nettype wire

// File: rtl/drt_route_mem.sv
// Route entry storage: one write port, one read port, registered read data.
// Depends on drt_pkg for the entry type.
`default_nettype none
module drt_route_mem #(
    parameter int ROUTES = drt_pkg::ROUTES_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(ROUTES)-1:0]  rd_addr,
    output drt_pkg::route_entry_t           rd_data,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(ROUTES)-1:0]  wr_addr,
    input  wire drt_pkg::route_entry_t      wr_data
);
    import drt_pkg::*;

    route_entry_t mem [ROUTES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: rtl/drt_ctrl.sv
// Sequencer of the route table: neighbor table, valid/seen bits, table scans,
// decision and dump output register, configuration registers.
// Depends on drt_pkg; drives the ports of drt_route_mem.
`default_nettype none
module drt_ctrl #(
    parameter int ROUTES    = drt_pkg::ROUTES_DEF,
    parameter int NEIGHBORS = drt_pkg::NEIGHBORS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire drt_pkg::in_item_t             in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output drt_pkg::out_item_t                 out_item,
    input  wire logic                          cfg_valid,
    input  wire logic [drt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [drt_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                               rd_en,
    output logic [$clog2(ROUTES)-1:0]          rd_addr,
    input  wire drt_pkg::route_entry_t         rd_data,
    output logic                               wr_en,
    output logic [$clog2(ROUTES)-1:0]          wr_addr,
    output drt_pkg::route_entry_t              wr_data
);
    import drt_pkg::*;

    localparam int IDX_W = $clog2(ROUTES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ROUTES - 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_WAIT, ST_POST, ST_EMIT,
        ST_DUMP_RD, ST_DUMP_DATA, ST_AGE
    } state_t;

    typedef enum logic [1:0] {OP_FIND, OP_PURGE, OP_EXPIRE} op_t;

    state_t       state_reg;
    state_t       ret_reg;
    op_t          op_reg;
    in_item_t     item_reg;
    logic [31:0]  key_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             scan_vld_reg;
    logic [IDX_W-1:0] scan_idx_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [47:0]      found_hop_reg;
    logic [15:0]      found_cost_reg;
    logic             dump_last_reg;

    logic [ROUTES-1:0] valid_reg;
    logic [ROUTES-1:0] seen_reg;
    logic [NEIGHBORS-1:0] nbr_valid_reg;
    logic [47:0]          nbr_addr_reg [NEIGHBORS];
    logic [7:0]           nbr_ticks_reg [NEIGHBORS];

    logic [31:0] own_ip_reg;
    logic [47:0] own_mac_reg;
    logic [7:0]  initial_ttl_reg;
    logic [7:0]  max_expiry_reg;

    logic [1:0]  pend_dec_reg;
    logic [47:0] pend_hop_reg;
    logic [7:0]  pend_ttl_reg;

    out_item_t out_reg;
    logic      out_valid_reg;

    // combinational helpers
    logic             free_any;
    logic [IDX_W-1:0] free_idx;
    logic                 nbr_hit_any, nbr_free_any;
    logic [NEIGHBORS-1:0] nbr_hit_mask, nbr_free_mask;
    logic                 exp_hit;
    logic [16:0]          sum_wide;
    logic [15:0]          sum_sat;
    logic [ROUTES-1:0]    valid_rest;
    logic                 dump_last;
    logic                 out_free;
    logic                 accept;
    logic                 seen_wr, seen_val, valid_wr;
    logic                 better;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign sum_wide = {1'b0, item_reg.link_distance} + {1'b0, item_reg.entry_distance};
    assign sum_sat  = sum_wide[16] ? COST_MAX : sum_wide[15:0];

    assign valid_rest = valid_reg >> idx_reg;
    assign dump_last  = (valid_rest[ROUTES-1:1] == '0);

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ROUTES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // neighbor lookup for refresh, on the incoming transaction
    always_comb
    begin
        nbr_hit_any   = 1'b0;
        nbr_free_any  = 1'b0;
        nbr_hit_mask  = '0;
        nbr_free_mask = '0;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            if (nbr_valid_reg[i] && nbr_addr_reg[i] == in_item.neighbor_mac && !nbr_hit_any)
            begin
                nbr_hit_mask[i] = 1'b1;
                nbr_hit_any     = 1'b1;
            end
            if (!nbr_valid_reg[i] && !nbr_free_any)
            begin
                nbr_free_mask[i] = 1'b1;
                nbr_free_any     = 1'b1;
            end
        end
    end

    always_comb
    begin
        exp_hit = 1'b0;
        for (int i = 0; i < NEIGHBORS; i++)
        begin
            if (nbr_valid_reg[i] && nbr_ticks_reg[i] == 8'd0
                && nbr_addr_reg[i] == rd_data.hop)
            begin
                exp_hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg;
        if (state_reg == ST_SCAN)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == ST_DUMP_RD && valid_reg[idx_reg] && out_free)
        begin
            rd_en = 1'b1;
        end
    end

    // write-back after a lookup
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = free_idx;
        wr_data  = '{dest: key_reg, hop: item_reg.neighbor_mac,
                     cost: item_reg.link_distance};
        valid_wr = 1'b0;
        seen_wr  = 1'b0;
        seen_val = 1'b0;
        better   = (item_reg.entry_next_hop != own_mac_reg) && (found_cost_reg > sum_sat);
        if (state_reg == ST_POST && ret_reg == ST_POST)
        begin
            unique case (item_reg.action)
                ACT_VSTART:
                begin
                    if (!found_reg && free_any)
                    begin
                        wr_en    = 1'b1;
                        valid_wr = 1'b1;
                        seen_wr  = 1'b1;
                    end
                end
                ACT_VENTRY:
                begin
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = found_idx_reg;
                        wr_data = '{dest: key_reg,
                                    hop: better ? item_reg.neighbor_mac : found_hop_reg,
                                    cost: (better || found_hop_reg == item_reg.neighbor_mac)
                                          ? sum_sat : found_cost_reg};
                        seen_wr  = 1'b1;
                        seen_val = 1'b1;
                    end
                    else if (item_reg.entry_next_hop != own_mac_reg && free_any)
                    begin
                        wr_en    = 1'b1;
                        wr_data  = '{dest: key_reg, hop: item_reg.neighbor_mac, cost: sum_sat};
                        valid_wr = 1'b1;
                        seen_wr  = 1'b1;
                        seen_val = 1'b1;
                    end
                end
                ACT_TICK:
                begin
                    wr_data = '{dest: own_ip_reg, hop: own_mac_reg, cost: 16'd0};
                    if (found_reg)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = found_idx_reg;
                    end
                    else if (free_any)
                    begin
                        wr_en    = 1'b1;
                        valid_wr = 1'b1;
                        seen_wr  = 1'b1;
                    end
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ret_reg         <= ST_POST;
            op_reg          <= OP_FIND;
            item_reg        <= '0;
            key_reg         <= '0;
            idx_reg         <= '0;
            scan_vld_reg    <= 1'b0;
            scan_idx_reg    <= '0;
            found_reg       <= 1'b0;
            found_idx_reg   <= '0;
            found_hop_reg   <= '0;
            found_cost_reg  <= '0;
            dump_last_reg   <= 1'b0;
            valid_reg       <= '0;
            seen_reg        <= '0;
            nbr_valid_reg   <= '0;
            for (int i = 0; i < NEIGHBORS; i++)
            begin
                nbr_addr_reg[i]  <= '0;
                nbr_ticks_reg[i] <= '0;
            end
            own_ip_reg      <= '0;
            own_mac_reg     <= '0;
            initial_ttl_reg <= TTL_RESET;
            max_expiry_reg  <= EXPIRY_RESET;
            pend_dec_reg    <= DEC_FLOOD;
            pend_hop_reg    <= '0;
            pend_ttl_reg    <= '0;
            out_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_OWN_IP:      own_ip_reg      <= cfg_data[31:0];
                    CFG_OWN_MAC:     own_mac_reg     <= cfg_data[47:0];
                    CFG_INITIAL_TTL: initial_ttl_reg <= cfg_data[7:0];
                    CFG_MAX_EXPIRY:  max_expiry_reg  <= cfg_data[7:0];
                    default:         own_ip_reg      <= own_ip_reg;
                endcase
            end

            if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            scan_vld_reg <= (state_reg == ST_SCAN);
            scan_idx_reg <= idx_reg;

            // returning read data of a scan
            if (scan_vld_reg && valid_reg[scan_idx_reg])
            begin
                unique case (op_reg)
                    OP_FIND:
                    begin
                        if (!found_reg && rd_data.dest == key_reg)
                        begin
                            found_reg      <= 1'b1;
                            found_idx_reg  <= scan_idx_reg;
                            found_hop_reg  <= rd_data.hop;
                            found_cost_reg <= rd_data.cost;
                        end
                    end
                    OP_PURGE:
                    begin
                        if (rd_data.hop == item_reg.neighbor_mac && !seen_reg[scan_idx_reg])
                        begin
                            valid_reg[scan_idx_reg] <= 1'b0;
                        end
                    end
                    OP_EXPIRE:
                    begin
                        if (exp_hit)
                        begin
                            valid_reg[scan_idx_reg] <= 1'b0;
                        end
                    end
                    default:
                    begin
                        found_reg <= found_reg;
                    end
                endcase
            end

            if (wr_en)
            begin
                if (valid_wr)
                begin
                    valid_reg[wr_addr] <= 1'b1;
                end
                if (seen_wr)
                begin
                    seen_reg[wr_addr] <= seen_val;
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg  <= in_item;
                        key_reg   <= in_item.target_ip;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        op_reg    <= OP_FIND;
                        ret_reg   <= ST_POST;
                        state_reg <= ST_SCAN;
                        if (in_item.action == ACT_DATA || in_item.action == ACT_VSTART)
                        begin
                            for (int i = 0; i < NEIGHBORS; i++)
                            begin
                                if (nbr_hit_mask[i] || (!nbr_hit_any && nbr_free_mask[i]))
                                begin
                                    nbr_valid_reg[i] <= 1'b1;
                                    nbr_addr_reg[i]  <= in_item.neighbor_mac;
                                    nbr_ticks_reg[i] <= max_expiry_reg;
                                end
                            end
                        end
                        priority case (in_item.action)
                            ACT_SEND:
                            begin
                                pend_ttl_reg <= initial_ttl_reg;
                            end
                            ACT_DATA:
                            begin
                                pend_ttl_reg <= in_item.ttl_in - 8'd1;
                                pend_hop_reg <= '0;
                                if (in_item.ttl_in == 8'd0)
                                begin
                                    pend_dec_reg <= DEC_DROP;
                                    pend_ttl_reg <= 8'd0;
                                    state_reg    <= ST_EMIT;
                                end
                                else if (in_item.target_ip == own_ip_reg)
                                begin
                                    pend_dec_reg <= DEC_DELIVER;
                                    pend_ttl_reg <= in_item.ttl_in;
                                    state_reg    <= ST_EMIT;
                                end
                            end
                            ACT_VSTART:
                            begin
                                seen_reg <= '0;
                                key_reg  <= in_item.neighbor_ip;
                            end
                            ACT_VENTRY:
                            begin
                                key_reg <= in_item.target_ip;
                            end
                            ACT_VEND:
                            begin
                                op_reg <= OP_PURGE;
                            end
                            ACT_TICK:
                            begin
                                key_reg <= own_ip_reg;
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_SCAN_WAIT;
                    end
                end
                ST_SCAN_WAIT:
                begin
                    state_reg <= ret_reg;
                end
                ST_POST:
                begin
                    state_reg <= ST_IDLE;
                    unique case (item_reg.action)
                        ACT_SEND, ACT_DATA:
                        begin
                            pend_dec_reg <= found_reg ? DEC_UNICAST : DEC_FLOOD;
                            pend_hop_reg <= found_reg ? found_hop_reg : 48'd0;
                            state_reg    <= ST_EMIT;
                        end
                        ACT_VEND:
                        begin
                            seen_reg <= '0;
                        end
                        ACT_TICK:
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_DUMP_RD;
                        end
                        default:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg <= '{kind: KIND_DECISION, decision: pend_dec_reg,
                                     next_hop_mac: pend_hop_reg, ttl_out: pend_ttl_reg,
                                     dump_ip: 32'd0, dump_next_hop: 48'd0,
                                     dump_distance: 16'd0, last: 1'b1};
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_DUMP_RD:
                begin
                    if (!valid_reg[idx_reg])
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                        if (idx_reg == IDX_LAST)
                        begin
                            idx_reg   <= '0;
                            op_reg    <= OP_EXPIRE;
                            ret_reg   <= ST_AGE;
                            state_reg <= ST_SCAN;
                        end
                    end
                    else if (out_free)
                    begin
                        dump_last_reg <= dump_last;
                        state_reg     <= ST_DUMP_DATA;
                    end
                end
                ST_DUMP_DATA:
                begin
                    out_reg <= '{kind: KIND_DUMP, decision: DEC_DELIVER,
                                 next_hop_mac: 48'd0, ttl_out: 8'd0,
                                 dump_ip: rd_data.dest, dump_next_hop: rd_data.hop,
                                 dump_distance: rd_data.cost, last: dump_last_reg};
                    out_valid_reg <= 1'b1;
                    idx_reg       <= idx_reg + IDX_W'(1);
                    state_reg     <= ST_DUMP_RD;
                    if (idx_reg == IDX_LAST)
                    begin
                        idx_reg   <= '0;
                        op_reg    <= OP_EXPIRE;
                        ret_reg   <= ST_AGE;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_AGE:
                begin
                    for (int i = 0; i < NEIGHBORS; i++)
                    begin
                        if (nbr_valid_reg[i])
                        begin
                            if (nbr_ticks_reg[i] == 8'd0)
                            begin
                                nbr_valid_reg[i] <= 1'b0;
                            end
                            else
                            begin
                                nbr_ticks_reg[i] <= nbr_ticks_reg[i] - 8'd1;
                            end
                        end
                    end
                    ret_reg   <= ST_POST;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: rtl/distance_vector_route_table_top.sv
// Top level of the distance-vector route table: sequencer plus route memory.
// Depends on drt_pkg, drt_ctrl and drt_route_mem.
//
//   channel | signals                          | transfers
//   --------+----------------------------------+--------------------------------
//   in      | in_valid, in_ready, in_item      | one action per transaction
//   out     | out_valid, out_ready, out_item   | one decision or dump entry
//   cfg     | cfg_valid, cfg_ready, cfg_index, | one register write
//           | cfg_data                         |
//
// One transaction at a time. Most actions scan the route memory once, one
// entry per cycle through its single read port. A tick adds a dump pass
// that reads and emits each valid route and skips empty slots, then a
// second scan for expired neighbors. Reset clears valid bits at once; no
// clearing pass. A stalled out channel holds the dump walk; cfg writes are
// taken in any cycle.
`default_nettype none
module distance_vector_route_table_top #(
    parameter int ROUTES    = drt_pkg::ROUTES_DEF,
    parameter int NEIGHBORS = drt_pkg::NEIGHBORS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire drt_pkg::in_item_t              in_item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output drt_pkg::out_item_t                  out_item,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [drt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [drt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import drt_pkg::*;

    localparam int IDX_W = $clog2(ROUTES);

    logic             rd_en, wr_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    route_entry_t     rd_data, wr_data;

    assign cfg_ready = 1'b1;

    drt_ctrl #(
        .ROUTES    (ROUTES),
        .NEIGHBORS (NEIGHBORS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    drt_route_mem #(
        .ROUTES (ROUTES)
    ) u_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule
`default_nettype wire

// File: rtl/drt_checker.sv
// Port-level checks for the route table top, attached by bind.
// Depends on drt_pkg and distance_vector_route_table_top.
`default_nettype none
module drt_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire drt_pkg::out_item_t out_item
);
    import drt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_decision_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_DECISION |-> out_item.last)
        else $error("decision not marked last");

    a_dump_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_DUMP |->
        out_item.decision == DEC_DELIVER && out_item.next_hop_mac == 48'd0
        && out_item.ttl_out == 8'd0)
        else $error("dump entry carries decision fields");

    a_decision_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.kind == KIND_DECISION |->
        out_item.dump_ip == 32'd0 && out_item.dump_next_hop == 48'd0
        && out_item.dump_distance == 16'd0
        && (out_item.decision == DEC_UNICAST || out_item.next_hop_mac == 48'd0))
        else $error("decision carries dump fields");

endmodule

bind distance_vector_route_table_top drt_checker u_drt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
`default_nettype wire

// File: tb/sv/tb_distance_vector_route_table_top.sv
// Self-checking testbench for distance_vector_route_table_top.
// Depends on drt_pkg and the block's RTL; holds its own route table predictor.
`timescale 1ns / 1ps
module tb_distance_vector_route_table_top;
    import drt_pkg::*;

    localparam int NROUTE = 32;
    localparam int NNBR   = 8;
    localparam int LIMIT  = 2000000;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  idx;
        logic [47:0] data;
        in_item_t    item;
    } pending_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    distance_vector_route_table_top i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predicted node state
    logic [31:0] p_own_ip;
    logic [47:0] p_own_mac;
    logic [7:0]  p_init_ttl, p_max_exp;
    bit          rt_valid [NROUTE];
    logic [31:0] rt_dest [NROUTE];
    logic [47:0] rt_hop [NROUTE];
    logic [15:0] rt_cost [NROUTE];
    bit          rt_seen [NROUTE];
    bit          nb_valid [NNBR];
    logic [47:0] nb_addr [NNBR];
    logic [7:0]  nb_ticks [NNBR];

    pending_t  pending_q [$];
    out_item_t expected_q [$];
    int errors = 0;
    int cycles = 0;
    bit hold_off = 0;
    bit hold_start = 0;
    bit in_taken = 0;
    bit cfg_taken = 0;

    function automatic int route_lookup(logic [31:0] ip);
        for (int i = 0; i < NROUTE; i++)
            if (rt_valid[i] && rt_dest[i] == ip) return i;
        return -1;
    endfunction

    function automatic int route_insert(logic [31:0] ip, logic [47:0] hop, logic [15:0] c);
        for (int i = 0; i < NROUTE; i++)
            if (!rt_valid[i]) begin
                rt_valid[i] = 1; rt_dest[i] = ip; rt_hop[i] = hop;
                rt_cost[i] = c; rt_seen[i] = 0;
                return i;
            end
        return -1;
    endfunction

    function automatic void nbr_refresh(logic [47:0] mac);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < NNBR; i++) begin
            if (nb_valid[i] && nb_addr[i] == mac) begin
                nb_ticks[i] = p_max_exp;
                return;
            end
            if (!nb_valid[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot >= 0) begin
            nb_valid[free_slot] = 1;
            nb_addr[free_slot] = mac;
            nb_ticks[free_slot] = p_max_exp;
        end
    endfunction

    function automatic void push_decision(logic [1:0] dec, logic [47:0] nh, logic [7:0] ttl);
        out_item_t o;
        o = '0;
        o.kind = KIND_DECISION; o.decision = dec; o.next_hop_mac = nh;
        o.ttl_out = ttl; o.last = 1'b1;
        expected_q.insert(expected_q.size(), o);
    endfunction

    function automatic void forward_decision(logic [31:0] dst, logic [7:0] ttl);
        int r;
        r = route_lookup(dst);
        if (r >= 0) push_decision(DEC_UNICAST, rt_hop[r], ttl);
        else push_decision(DEC_FLOOD, '0, ttl);
    endfunction

    function automatic void predict_route_table(in_item_t it);
        int r, lastk;
        logic [16:0] sum17;
        logic [15:0] sum;
        out_item_t o;
        case (it.action)
            ACT_SEND: forward_decision(it.target_ip, p_init_ttl);
            ACT_DATA: begin
                nbr_refresh(it.neighbor_mac);
                if (it.ttl_in == 0) push_decision(DEC_DROP, '0, '0);
                else if (it.target_ip == p_own_ip) push_decision(DEC_DELIVER, '0, it.ttl_in);
                else forward_decision(it.target_ip, it.ttl_in - 8'd1);
            end
            ACT_VSTART: begin
                nbr_refresh(it.neighbor_mac);
                for (int i = 0; i < NROUTE; i++) rt_seen[i] = 0;
                if (route_lookup(it.neighbor_ip) < 0)
                    void'(route_insert(it.neighbor_ip, it.neighbor_mac, it.link_distance));
            end
            ACT_VENTRY: begin
                sum17 = {1'b0, it.link_distance} + {1'b0, it.entry_distance};
                sum = sum17[16] ? COST_MAX : sum17[15:0];
                r = route_lookup(it.target_ip);
                if (it.entry_next_hop != p_own_mac) begin
                    if (r < 0) r = route_insert(it.target_ip, it.neighbor_mac, sum);
                    else if (rt_cost[r] > sum) begin
                        rt_hop[r] = it.neighbor_mac;
                        rt_cost[r] = sum;
                    end
                end
                if (r >= 0) begin
                    if (rt_hop[r] == it.neighbor_mac) rt_cost[r] = sum;
                    rt_seen[r] = 1;
                end
            end
            ACT_VEND: begin
                for (int i = 0; i < NROUTE; i++) begin
                    if (rt_valid[i] && rt_hop[i] == it.neighbor_mac && !rt_seen[i])
                        rt_valid[i] = 0;
                    rt_seen[i] = 0;
                end
            end
            ACT_TICK: begin
                r = route_lookup(p_own_ip);
                if (r < 0) r = route_insert(p_own_ip, p_own_mac, '0);
                if (r >= 0) begin
                    rt_hop[r] = p_own_mac;
                    rt_cost[r] = '0;
                end
                lastk = -1;
                for (int i = 0; i < NROUTE; i++)
                    if (rt_valid[i]) lastk = i;
                for (int i = 0; i < NROUTE; i++)
                    if (rt_valid[i]) begin
                        o = '0;
                        o.kind = KIND_DUMP; o.dump_ip = rt_dest[i];
                        o.dump_next_hop = rt_hop[i]; o.dump_distance = rt_cost[i];
                        o.last = (i == lastk);
                        expected_q.insert(expected_q.size(), o);
                    end
                for (int i = 0; i < NNBR; i++) begin
                    if (!nb_valid[i]) continue;
                    if (nb_ticks[i] == 0) begin
                        nb_valid[i] = 0;
                        for (int j = 0; j < NROUTE; j++)
                            if (rt_valid[j] && rt_hop[j] == nb_addr[i]) rt_valid[j] = 0;
                    end else begin
                        nb_ticks[i]--;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [47:0] d);
        case (idx)
            CFG_OWN_IP:      p_own_ip = d[31:0];
            CFG_OWN_MAC:     p_own_mac = d;
            CFG_INITIAL_TTL: p_init_ttl = d[7:0];
            CFG_MAX_EXPIRY:  p_max_exp = d[7:0];
            default: ;
        endcase
    endfunction

    // address pools keep lookups hitting
    logic [31:0] ip_pool [8];
    logic [47:0] mac_pool [6];

    function automatic logic [47:0] rnd48();
        return {16'($urandom_range(0, 65535)), $urandom()};
    endfunction

    function automatic logic [31:0] pick_ip();
        return ($urandom_range(0, 9) == 0) ? $urandom() : ip_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [47:0] pick_mac();
        return ($urandom_range(0, 11) == 0) ? rnd48() : mac_pool[$urandom_range(0, 5)];
    endfunction

    function automatic in_item_t rand_item(logic [2:0] act);
        in_item_t it;
        it.action = act;
        it.neighbor_mac = pick_mac();
        it.neighbor_ip = pick_ip();
        it.target_ip = pick_ip();
        it.ttl_in = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom());
        it.link_distance = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(1, 20));
        it.entry_next_hop = ($urandom_range(0, 5) == 0) ? 48'h0 : pick_mac();
        it.entry_distance = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 30));
        return it;
    endfunction

    task automatic queue_item(in_item_t it);
        pending_t p;
        p.is_cfg = 0; p.idx = '0; p.data = '0; p.item = it;
        pending_q.push_back(p);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [47:0] d);
        pending_t p;
        p.is_cfg = 1; p.idx = idx; p.data = d; p.item = '0;
        pending_q.push_back(p);
    endtask

    // lets the queue drain, then waits out the block's own latency
    task automatic settle();
        wait (pending_q.size() == 0 && !in_valid && !cfg_valid && expected_q.size() == 0);
        repeat (3 * NROUTE + 20) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] ip, logic [47:0] mac, logic [7:0] ttl, logic [7:0] ex);
        settle();
        write_reg(CFG_OWN_IP, {16'h0, ip});
        write_reg(CFG_OWN_MAC, mac);
        write_reg(CFG_INITIAL_TTL, {40'h0, ttl});
        write_reg(CFG_MAX_EXPIRY, {40'h0, ex});
        wait (pending_q.size() == 0 && !cfg_valid);
    endtask

    task automatic vector_burst(int entries);
        in_item_t it;
        logic [47:0] mac;
        mac = mac_pool[$urandom_range(0, 5)];
        it = rand_item(ACT_VSTART); it.neighbor_mac = mac; queue_item(it);
        for (int k = 0; k < entries; k++) begin
            it = rand_item(ACT_VENTRY); it.neighbor_mac = mac; queue_item(it);
        end
        it = rand_item(ACT_VEND); it.neighbor_mac = mac; queue_item(it);
    endtask

    initial begin
        forever #5 clk = ~clk;
    end

    // handshakes seen at the rising edge, used by the driver at the falling edge
    always @(posedge clk) begin
        in_taken <= in_valid && in_ready;
        cfg_taken <= cfg_valid && cfg_ready;
    end

    // driver: one transaction at a time from the pending queue
    int gap = 0;
    always @(negedge clk) begin
        pending_t p;
        bit in_next, cfg_next;
        if (rst_n) begin
            in_next = in_valid && !in_taken;
            cfg_next = cfg_valid && !cfg_taken;
            if (!in_next && !cfg_next) begin
                if (gap > 0) gap <= gap - 1;
                else if (pending_q.size() > 0) begin
                    p = pending_q.pop_front();
                    gap <= $urandom_range(0, 12);
                    if (p.is_cfg) begin
                        apply_reg(p.idx, p.data);
                        cfg_index <= p.idx;
                        cfg_data <= p.data;
                        cfg_next = 1'b1;
                    end else begin
                        predict_route_table(p.item);
                        in_item <= p.item;
                        in_next = 1'b1;
                    end
                end
            end
            in_valid <= in_next;
            cfg_valid <= cfg_next;
        end
    end

    // long receiver hold-off, counted here
    initial begin
        wait (hold_start);
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
    end

    // receiver ready pattern
    int stall = 0;
    always @(negedge clk) begin
        if (hold_off) out_ready <= 1'b0;
        else if (stall > 0) begin
            out_ready <= 1'b0;
            stall <= stall - 1;
        end else if (out_ready && out_valid) begin
            if ($urandom_range(0, 2) == 0) begin
                out_ready <= 1'b1;
            end else begin
                stall <= $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
        end else out_ready <= 1'b1;
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, out_item);
                errors++;
            end else begin
                out_item_t e;
                e = expected_q.pop_front();
                if (out_item !== e) begin
                    $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        in_item_t it;
        int act;
        p_own_ip = '0; p_own_mac = '0; p_init_ttl = TTL_RESET; p_max_exp = EXPIRY_RESET;
        for (int i = 0; i < NROUTE; i++) begin
            rt_valid[i] = 0; rt_seen[i] = 0; rt_dest[i] = '0; rt_hop[i] = '0; rt_cost[i] = '0;
        end
        for (int i = 0; i < NNBR; i++) begin
            nb_valid[i] = 0; nb_addr[i] = '0; nb_ticks[i] = '0;
        end
        for (int i = 0; i < 8; i++) ip_pool[i] = $urandom();
        for (int i = 0; i < 6; i++) mac_pool[i] = rnd48();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset config, then extremes
        it = rand_item(ACT_TICK); queue_item(it);
        it = rand_item(ACT_SEND); queue_item(it);
        it = rand_item(ACT_DATA); it.ttl_in = 8'd0; queue_item(it);
        it = rand_item(ACT_DATA); it.ttl_in = 8'hFF; it.target_ip = '0; queue_item(it);
        it = rand_item(ACT_DATA); it.ttl_in = 8'd1; it.target_ip = 32'hFFFFFFFF; queue_item(it);
        write_all(32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 8'hFF, 8'd0);
        it = rand_item(ACT_VSTART); it.neighbor_mac = 48'h0; it.neighbor_ip = 32'h0;
        it.link_distance = 16'hFFFF; queue_item(it);
        it = rand_item(ACT_VENTRY); it.neighbor_mac = 48'h0; it.link_distance = 16'hFFFF;
        it.entry_distance = 16'hFFFF; it.entry_next_hop = 48'h1; queue_item(it);
        // next hop equal to own address: no insert
        it = rand_item(ACT_VENTRY); it.entry_next_hop = 48'hFFFFFFFFFFFF; queue_item(it);
        it = rand_item(ACT_VEND); it.neighbor_mac = 48'h0; queue_item(it);
        it = rand_item(ACT_SEND); it.target_ip = 32'h0; queue_item(it);
        it = rand_item(ACT_DATA); it.target_ip = 32'hFFFFFFFF; it.ttl_in = 8'd7; queue_item(it);
        it = rand_item(3'd6); queue_item(it);
        it = rand_item(3'd7); queue_item(it);
        it = rand_item(ACT_TICK); queue_item(it);
        it = rand_item(ACT_TICK); queue_item(it);
        // table full: many distinct destinations from one neighbor
        write_all(32'h0A000001, 48'h020000000001, 8'd0, 8'd255);
        it = rand_item(ACT_VSTART); it.neighbor_mac = mac_pool[0]; queue_item(it);
        for (int k = 0; k < 36; k++) begin
            it = rand_item(ACT_VENTRY); it.neighbor_mac = mac_pool[0];
            it.target_ip = $urandom(); it.entry_next_hop = 48'h5; queue_item(it);
        end
        it = rand_item(ACT_SEND); queue_item(it);
        // long receiver hold-off while a tick dumps a full table
        wait (pending_q.size() == 0);
        hold_start = 1;
        it = rand_item(ACT_TICK); queue_item(it);
        it = rand_item(ACT_SEND); queue_item(it);
        it = rand_item(ACT_SEND); queue_item(it);

        // random phases
        for (int ph = 0; ph < 4; ph++) begin
            write_all($urandom(), rnd48(), 8'($urandom()), 8'($urandom_range(0, 4)));
            if (ph == 1) write_all(ip_pool[0], mac_pool[0], 8'd1, 8'd2);
            for (int n = 0; n < 70; ) begin
                act = $urandom_range(0, 9);
                if (act < 4) begin
                    vector_burst($urandom_range(0, 5));
                    n += 3;
                end else begin
                    case (act)
                        4, 5: it = rand_item(ACT_SEND);
                        6, 7: it = rand_item(ACT_DATA);
                        8: it = rand_item(ACT_TICK);
                        default: it = rand_item(3'($urandom_range(0, 7)));
                    endcase
                    queue_item(it);
                    n++;
                end
            end
        end
        settle();
        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
